// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is checked during reset as well
`define ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfr_pkg
// Types, codes and the CRC32C byte step shared by the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccfr_pkg;

    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] HDR_FTR_BYTES = 32'd9;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

    typedef enum logic [2:0] {
        PH_CMD     = 3'd0,
        PH_SIZE    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC     = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        VERD_OK      = 2'd0,
        VERD_BAD_LEN = 2'd1,
        VERD_CRC_ERR = 2'd2,
        VERD_RANGE   = 2'd3
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        logic        emit;
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        t_verdict    verdict;
        logic [31:0] payload_length;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/ccfr_parser.sv =====
// ----------------------------------------------------------------------------
// ccfr_parser
// Frame state machine: header, payload and footer parsing with CRC32C check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccfr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_max_payload,
    output ccfr_pkg::t_result  o_result
);

    ccfr_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_count, n_count;
    logic [31:0]      r_crc,   n_crc;
    logic [23:0]      r_size,  n_size;
    logic [23:0]      r_rcv,   n_rcv;
    logic [31:0]      r_plen,  n_plen;
    logic [7:0]       r_cmd,   n_cmd;

    logic [31:0] size_full;
    logic [31:0] rcv_full;
    logic [31:0] count_inc;
    logic        in_range;

    assign size_full = {i_byte, r_size};
    assign rcv_full  = {i_byte, r_rcv};
    assign count_inc = r_count + 32'd1;
    assign in_range  = r_plen <= {16'd0, i_max_payload};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ccfr_pkg::PH_CMD;
            r_count <= '0;
            r_crc   <= ccfr_pkg::CRC_INIT;
            r_rcv   <= '0;
            r_size  <= '0;
            r_plen  <= '0;
            r_cmd   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
            r_size  <= n_size;
            r_plen  <= n_plen;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_crc    = r_crc;
        n_size   = r_size;
        n_rcv    = r_rcv;
        n_plen   = r_plen;
        n_cmd    = r_cmd;
        o_result = '0;
        o_result.command = r_cmd;
        unique case (r_phase)
            ccfr_pkg::PH_SIZE: begin
                n_crc   = ccfr_pkg::crc_byte(r_crc, i_byte);
                n_count = count_inc;
                unique case (r_count[1:0])
                    2'd0: n_size[7:0]   = i_byte;
                    2'd1: n_size[15:8]  = i_byte;
                    2'd2: n_size[23:16] = i_byte;
                    default: begin
                        n_count = '0;
                        if (size_full < ccfr_pkg::HDR_FTR_BYTES) begin
                            o_result.emit    = 1'b1;
                            o_result.kind    = ccfr_pkg::KIND_VERDICT;
                            o_result.verdict = ccfr_pkg::VERD_BAD_LEN;
                            n_phase = ccfr_pkg::PH_CMD;
                            n_crc   = ccfr_pkg::CRC_INIT;
                            n_rcv   = '0;
                        end else begin
                            n_plen  = size_full - ccfr_pkg::HDR_FTR_BYTES;
                            n_phase = (size_full == ccfr_pkg::HDR_FTR_BYTES) ?
                                      ccfr_pkg::PH_CRC : ccfr_pkg::PH_PAYLOAD;
                        end
                    end
                endcase
            end
            ccfr_pkg::PH_PAYLOAD: begin
                n_crc   = ccfr_pkg::crc_byte(r_crc, i_byte);
                n_count = count_inc;
                if (count_inc >= r_plen) begin
                    n_count = '0;
                    n_phase = ccfr_pkg::PH_CRC;
                end
                if (in_range) begin
                    o_result.emit           = 1'b1;
                    o_result.kind           = ccfr_pkg::KIND_PAYLOAD;
                    o_result.payload_byte   = i_byte;
                    o_result.verdict        = ccfr_pkg::VERD_OK;
                    o_result.payload_length = r_plen;
                end
            end
            ccfr_pkg::PH_CRC: begin
                n_count = count_inc;
                unique case (r_count[1:0])
                    2'd0: n_rcv[7:0]   = i_byte;
                    2'd1: n_rcv[15:8]  = i_byte;
                    2'd2: n_rcv[23:16] = i_byte;
                    default: begin
                        o_result.emit           = 1'b1;
                        o_result.kind           = ccfr_pkg::KIND_VERDICT;
                        o_result.payload_length = r_plen;
                        if ((r_crc ^ ccfr_pkg::CRC_INIT) != rcv_full) begin
                            o_result.verdict = ccfr_pkg::VERD_CRC_ERR;
                        end else if (!in_range) begin
                            o_result.verdict = ccfr_pkg::VERD_RANGE;
                        end else begin
                            o_result.verdict = ccfr_pkg::VERD_OK;
                        end
                        n_phase = ccfr_pkg::PH_CMD;
                        n_count = '0;
                        n_crc   = ccfr_pkg::CRC_INIT;
                        n_rcv   = '0;
                    end
                endcase
            end
            default: begin
                n_cmd   = i_byte;
                n_size  = '0;
                n_count = '0;
                n_rcv   = '0;
                n_crc   = ccfr_pkg::crc_byte(ccfr_pkg::CRC_INIT, i_byte);
                n_phase = ccfr_pkg::PH_SIZE;
            end
        endcase
    end

endmodule

// ===== rtl/crc32c_command_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// crc32c_command_frame_receiver_unit
// Length-prefixed command frame receiver with CRC32C footer check.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while o_stall is low. A byte lands in an input
// register, passes the frame state machine and one CRC32C byte step when it
// fires, and any request it causes sits in the output register. The CRC
// byte step between the two registers handles a whole byte at once, which
// sets that rate. Output stall backs up into the input stall only when both
// registers are full. max_payload may be written while idle.
`timescale 1ns / 1ps

module crc32c_command_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_command,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_payload_length
);

    logic [15:0]       r_max_payload;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    ccfr_pkg::t_result r_out;
    ccfr_pkg::t_result result;
    logic              out_free;
    logic              fire;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= ccfr_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    // input register: take a request when empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    ccfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_result      (result)
    );

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_command        = r_out.command;
    assign o_verdict        = r_out.verdict;
    assign o_payload_length = r_out.payload_length;

endmodule

// ===== rtl/ccfr_checker.sv =====
// ----------------------------------------------------------------------------
// ccfr_checker
// Port-level checks on the frame receiver result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [1:0]  o_verdict,
    input logic [31:0] o_payload_length
);

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_payload_length) && $stable(o_verdict), "stalled result changed")
    `ASSERT_IMPLY(a_verd_pb, i_clk, i_rst_n, o_valid && o_kind, o_payload_byte == 8'd0, "verdict carries a payload byte")
    `ASSERT_IMPLY(a_pay_ok, i_clk, i_rst_n, o_valid && !o_kind, o_verdict == 2'(ccfr_pkg::VERD_OK), "payload byte with verdict set")
    `ASSERT_IMPLY(a_badlen, i_clk, i_rst_n, o_valid && o_kind && (o_verdict == 2'(ccfr_pkg::VERD_BAD_LEN)), o_payload_length == 32'd0, "bad length with nonzero length")
    `ASSERT_ALWAYS_NEXT(a_rst, i_clk, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind crc32c_command_frame_receiver_unit ccfr_checker u_ccfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_payload_byte   (o_payload_byte),
    .o_verdict        (o_verdict),
    .o_payload_length (o_payload_length)
);
